### rtl/assert_macros.svh
// Assertion macros shared by the max flow block.
// Header only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### rtl/mfa_pkg.sv
// Package for the max flow block: sizes, payload structs, control structs.
// No dependencies.
`timescale 1ns / 1ps
package mfa_pkg;
	localparam int NODES    = 8;
	localparam int NODE_W   = 3;
	localparam int CAP_BITS = 8;
	localparam int RES_W    = CAP_BITS + 4;
	localparam int CELLS    = NODES * NODES;
	localparam int ADDR_W   = 2 * NODE_W;
	localparam int CNT_W    = ADDR_W + 1;
	localparam int OUT_W    = 11;
	localparam int SUM_W    = 24;
	localparam logic [OUT_W-1:0] OUT_MAX = 11'd2047;
	localparam logic [0:0] REG_SOURCE = 1'b0;
	localparam logic [0:0] REG_SINK   = 1'b1;

	typedef struct packed {
		logic [2:0] from_node;
		logic [2:0] to_node;
		logic [7:0] edge_capacity;
		logic       last_edge;
	} edge_item_t;

	typedef struct packed {
		logic [10:0] total_flow;
		logic [10:0] paths_found;
	} flow_result_t;

	// Controller to datapath.
	typedef struct packed {
		logic clr_cap;         // clear capacity valid bits
		logic copy_rd;         // read capacity cell cnt
		logic copy_wr;         // write residual cell read last cycle
		logic init_search;     // reset marks, stack = {source}
		logic pop;             // pop top into cur
		logic scan_rd;         // read residual[cur][cnt]
		logic scan;            // evaluate neighbor read last cycle
		logic trace_start;     // node = sink, bottleneck = max
		logic trace_rd;        // read residual[parent][node], step node
		logic walk_start;      // node = sink, keep bottleneck
		logic upd_rd;          // read residual[parent][node]
		logic upd_fwd;         // residual[parent][node] -= bn, read backward cell
		logic upd_bwd;         // residual[node][parent] += bn, step node
		logic accum;           // add bottleneck to totals
		logic clr_tot;         // clear totals
		logic [CNT_W-1:0] cnt; // sweep counter
	} mfa_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic stack_empty;
		logic cur_is_sink;
		logic hit_sink;       // scan pushed the sink
		logic trace_done;     // node is source
		logic bad_ends;
	} mfa_stat_t;
endpackage

### rtl/max_flow_dfs_augment.sv
// Max flow top level: edge load, DFS augmenting controller and datapath.
// Flow: after the last edge item, a copy sweep fills the residual store, then
// the DFS pops and scans nodes, and per path found a trace finds the bottleneck
// and an update walk adjusts the residuals; a done state ends it.
// Throughput: edges one per cycle when idle; busy stays high the whole search.
// Reset: asynchronous active low; capacity store reads zero, source 0, sink 7.
`timescale 1ns / 1ps
module max_flow_dfs_augment (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  mfa_pkg::edge_item_t   item,
	output logic                  done,
	output mfa_pkg::flow_result_t result,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [2:0]            cfg_data
);
	import mfa_pkg::*;

	logic [2:0] src_q, snk_q;
	logic       acc;
	mfa_cmd_t   cmd;
	mfa_stat_t  stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 3'd0;
			snk_q <= 3'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE: src_q <= cfg_data;
				REG_SINK:   snk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign acc = start && !busy;

	mfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(acc && item.last_edge),
		.stat(stat), .cmd(cmd), .busy(busy), .done(done)
	);

	mfa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .wr_en(acc), .wr_item(item),
		.src(src_q), .snk(snk_q), .cmd(cmd), .stat(stat), .result(result)
	);
endmodule

### rtl/mfa_datapath.sv
// Datapath of the max flow block: capacity/residual stores, DFS stack, totals.
// Depends on mfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfa_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  mfa_pkg::edge_item_t       wr_item,
	input  logic [2:0]                src,
	input  logic [2:0]                snk,
	input  mfa_pkg::mfa_cmd_t         cmd,
	output mfa_pkg::mfa_stat_t        stat,
	output mfa_pkg::flow_result_t     result
);
	import mfa_pkg::*;

	// capacity store with valid bits (reset reads zero)
	logic [CAP_BITS-1:0] cap_q [CELLS];
	logic [CELLS-1:0]    cap_v_q;
	logic [CAP_BITS-1:0] cap_rd_s1;
	logic                cap_v_s1;
	logic [ADDR_W-1:0]   cp_a_s1;
	logic [RES_W-1:0]    res_q [CELLS];
	logic [RES_W-1:0]    res_rd_q;
	logic [NODE_W-1:0]   stk_q [NODES+1];
	logic [NODE_W:0]     sp_q;
	logic [NODES-1:0]    mark_q;
	logic [NODE_W-1:0]   par_q [NODES];
	logic [NODE_W-1:0]   cur_q, node_q, nb_s1;
	logic [RES_W-1:0]    bn_q;
	logic                trace_v_s1;
	logic [SUM_W-1:0]    flow_q, cnt_paths_q;
	logic [ADDR_W-1:0]   sc_a, tr_a, bw_a;
	logic                push;

	assign sc_a = {cur_q, cmd.cnt[NODE_W-1:0]};
	assign tr_a = {par_q[node_q], node_q};
	assign bw_a = {node_q, par_q[node_q]};
	assign push = cmd.scan && (res_rd_q != '0) && !mark_q[nb_s1];

	// edge load and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_v_q <= '0;
		end else if (cmd.clr_cap) begin
			cap_v_q <= '0;
		end else if (wr_en) begin
			cap_v_q[{wr_item.from_node, wr_item.to_node}] <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (wr_en)
			cap_q[{wr_item.from_node, wr_item.to_node}] <= wr_item.edge_capacity;
	end

	// capacity read for the copy sweep, registered
	always_ff @(posedge clk) begin
		if (cmd.copy_rd) begin
			cap_rd_s1 <= cap_q[cmd.cnt[ADDR_W-1:0]];
			cap_v_s1  <= cap_v_q[cmd.cnt[ADDR_W-1:0]];
			cp_a_s1   <= cmd.cnt[ADDR_W-1:0];
		end
	end

	// residual read port, registered
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			res_rd_q <= res_q[sc_a];
			nb_s1    <= cmd.cnt[NODE_W-1:0];
		end else if (cmd.trace_rd || cmd.upd_rd) begin
			res_rd_q <= res_q[tr_a];
		end else if (cmd.upd_fwd) begin
			res_rd_q <= res_q[bw_a];
		end
	end

	// residual write port: copy and augment, one cell per cycle
	always_ff @(posedge clk) begin
		if (cmd.copy_wr) begin
			res_q[cp_a_s1] <= cap_v_s1 ? RES_W'(cap_rd_s1) : '0;
		end else if (cmd.upd_fwd) begin
			res_q[tr_a] <= res_rd_q - bn_q;
		end else if (cmd.upd_bwd) begin
			res_q[bw_a] <= res_rd_q + bn_q;
		end
	end

	// stack pointer and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			mark_q <= '0;
		end else if (cmd.init_search) begin
			sp_q   <= (NODE_W+1)'(1);
			mark_q <= NODES'(1) << src;
		end else if (cmd.pop) begin
			sp_q <= sp_q - 1'b1;
		end else if (push) begin
			sp_q       <= sp_q + 1'b1;
			mark_q[nb_s1] <= 1'b1;
		end
	end

	// stack entries, current node, parents
	always_ff @(posedge clk) begin
		if (cmd.init_search) begin
			stk_q[0] <= src;
		end else if (cmd.pop) begin
			cur_q <= stk_q[sp_q - 1'b1];
		end else if (push) begin
			stk_q[sp_q]  <= nb_s1;
			par_q[nb_s1] <= cur_q;
		end
	end

	// path walk pointer
	always_ff @(posedge clk) begin
		if (cmd.trace_start || cmd.walk_start) begin
			node_q <= snk;
		end else if (cmd.trace_rd || cmd.upd_bwd) begin
			node_q <= par_q[node_q];
		end
	end

	// bottleneck: minimum of the residuals read during the trace
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_v_s1 <= 1'b0;
		end else begin
			trace_v_s1 <= cmd.trace_rd;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.trace_start) begin
			bn_q <= '1;
		end else if (trace_v_s1 && (res_rd_q < bn_q)) begin
			bn_q <= res_rd_q;
		end
	end

	// totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q      <= '0;
			cnt_paths_q <= '0;
		end else if (cmd.clr_tot) begin
			flow_q      <= '0;
			cnt_paths_q <= '0;
		end else if (cmd.accum) begin
			flow_q      <= flow_q + SUM_W'(bn_q);
			cnt_paths_q <= cnt_paths_q + 1'b1;
		end
	end

	assign stat.stack_empty = (sp_q == 0);
	assign stat.cur_is_sink = (cur_q == snk);
	assign stat.hit_sink    = push && (nb_s1 == snk);
	assign stat.trace_done  = (node_q == src);
	assign stat.bad_ends    = (src == snk);
	assign result.total_flow  = (flow_q > SUM_W'(OUT_MAX)) ? OUT_MAX : flow_q[OUT_W-1:0];
	assign result.paths_found = (cnt_paths_q > SUM_W'(OUT_MAX)) ? OUT_MAX :
		cnt_paths_q[OUT_W-1:0];

	`ASSERT_IMPLIES(a_stack_bound, clk, arst_n, 1'b1, sp_q <= (NODE_W+1)'(NODES + 1))
	`ASSERT_NEXT(a_init_mark, clk, arst_n, cmd.init_search, mark_q[src] && sp_q == 1)
	`ASSERT_IMPLIES(a_push_unmarked, clk, arst_n, push, !mark_q[nb_s1])
endmodule

### rtl/mfa_ctrl.sv
// Controller state machine of the max flow block.
// Depends on mfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  mfa_pkg::mfa_stat_t stat,
	output mfa_pkg::mfa_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import mfa_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b0_0000_0001,
		S_COPY    = 9'b0_0000_0010,
		S_POP     = 9'b0_0000_0100,
		S_SCAN    = 9'b0_0000_1000,
		S_TRACE   = 9'b0_0001_0000,
		S_UPD_RD  = 9'b0_0010_0000,
		S_UPD_FWD = 9'b0_0100_0000,
		S_UPD_BWD = 9'b0_1000_0000,
		S_DONE    = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		case (state_q)
			S_IDLE: begin
				cmd.clr_tot = go;
				if (go) begin
					state_d = S_COPY;
					cnt_d   = '0;
				end
			end
			S_COPY: begin
				// read cell cnt, write cell cnt-1 from the registered read
				cmd.copy_rd = (cnt_q != CNT_W'(CELLS));
				cmd.copy_wr = (cnt_q != '0);
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CELLS)) begin
					cmd.init_search = 1'b1;
					state_d = stat.bad_ends ? S_DONE : S_POP;
				end
			end
			S_POP: begin
				// cur holds popped node after this cycle
				if (stat.stack_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_SCAN;
					cnt_d   = '0;
				end
			end
			S_SCAN: begin
				if (cnt_q == '0 && stat.cur_is_sink) begin
					cmd.trace_start = 1'b1;
					state_d = S_TRACE;
				end else begin
					// read neighbor cnt, evaluate neighbor cnt-1
					cmd.scan_rd = (cnt_q < CNT_W'(NODES));
					cmd.scan    = (cnt_q != '0);
					cnt_d       = cnt_q + 1'b1;
					if (stat.hit_sink) begin
						cmd.trace_start = 1'b1;
						state_d = S_TRACE;
					end else if (cnt_q == CNT_W'(NODES)) begin
						state_d = S_POP;
					end
				end
			end
			S_TRACE: begin
				// last read is folded into the bottleneck in the exit cycle
				if (stat.trace_done) begin
					cmd.walk_start = 1'b1;
					state_d = S_UPD_RD;
				end else begin
					cmd.trace_rd = 1'b1;
				end
			end
			S_UPD_RD: begin
				if (stat.trace_done) begin
					cmd.accum       = 1'b1;
					cmd.init_search = 1'b1;
					state_d = S_POP;
				end else begin
					cmd.upd_rd = 1'b1;
					state_d = S_UPD_FWD;
				end
			end
			S_UPD_FWD: begin
				cmd.upd_fwd = 1'b1;
				state_d = S_UPD_BWD;
			end
			S_UPD_BWD: begin
				cmd.upd_bwd = 1'b1;
				state_d = S_UPD_RD;
			end
			S_DONE: begin
				cmd.clr_cap = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`ASSERT_IMPLIES(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`ASSERT_NEXT(a_done_idle, clk, arst_n, done, state_q == S_IDLE)
	`ASSERT_IMPLIES(a_no_go_busy, clk, arst_n, busy, !cmd.clr_tot)
endmodule

### bench/max_flow_dfs_augment_tb.sv
// Self-checking bench for max_flow_dfs_augment: loads random capacity graphs,
// predicts max flow and path count by DFS augmentation, and checks each result.
// Depends on mfa_pkg and the max_flow_dfs_augment RTL.
`timescale 1ns / 1ps

// Scoreboard: keeps its own capacity matrix and the expected flow results.
class flow_scoreboard;
	int unsigned cap_mat[8][8];
	int unsigned src_cfg;
	int unsigned snk_cfg;
	mfa_pkg::flow_result_t pending_flows[$];
	int errors;
	int checked;

	function void clear_graph();
		foreach (cap_mat[i, j]) cap_mat[i][j] = 0;
	endfunction

	// One DFS from src; returns path length (nodes), 0 when sink unreached.
	function int dfs_route(ref int unsigned resid[8][8], input int unsigned s,
			input int unsigned t, output int unsigned path[8]);
		int unsigned par[8];
		bit mark[8];
		int unsigned stk[9];
		int sp;
		int unsigned cur;
		int len;
		int unsigned node;
		bit hit;
		for (int i = 0; i < 8; i++) begin
			par[i] = 15;
			mark[i] = 0;
		end
		sp = 0;
		stk[sp++] = s;
		mark[s] = 1;
		hit = 0;
		while (sp > 0 && !hit) begin
			cur = stk[--sp];
			if (cur == t) break;
			for (int i = 0; i < 8; i++) begin
				if (resid[cur][i] > 0 && !mark[i]) begin
					if (sp < 9) stk[sp++] = i;
					mark[i] = 1;
					par[i] = cur;
					if (i == t) begin
						hit = 1;
						break;
					end
				end
			end
		end
		if (par[t] == 15) return 0;
		len = 0;
		node = t;
		while (node != 15 && len < 8) begin
			len++;
			node = par[node];
		end
		node = t;
		for (int p = len - 1; p >= 0; p--) begin
			path[p] = node;
			node = par[node];
		end
		return len;
	endfunction

	// Record an accepted edge; on the last edge predict the flow result.
	function void note_edge(mfa_pkg::edge_item_t it);
		int unsigned resid[8][8];
		int unsigned path[8];
		int len;
		int unsigned bn;
		int unsigned sum;
		int unsigned cnt;
		mfa_pkg::flow_result_t r;
		cap_mat[it.from_node][it.to_node] = 32'(it.edge_capacity);
		if (!it.last_edge) return;
		resid = cap_mat;
		sum = 0;
		cnt = 0;
		if (src_cfg != snk_cfg) begin
			forever begin
				len = dfs_route(resid, src_cfg, snk_cfg, path);
				if (len < 2) break;
				bn = resid[path[0]][path[1]];
				for (int k = 1; k + 1 < len; k++)
					if (resid[path[k]][path[k+1]] < bn) bn = resid[path[k]][path[k+1]];
				for (int k = 0; k + 1 < len; k++) begin
					resid[path[k]][path[k+1]] -= bn;
					resid[path[k+1]][path[k]] += bn;
				end
				sum += bn;
				cnt++;
			end
		end
		r.total_flow = sum > 2047 ? 11'd2047 : sum[10:0];
		r.paths_found = cnt > 2047 ? 11'd2047 : cnt[10:0];
		pending_flows.push_back(r);
		clear_graph();
	endfunction

	task report(string what, int unsigned got, int unsigned want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_result(mfa_pkg::flow_result_t r);
		mfa_pkg::flow_result_t w;
		checked++;
		if (pending_flows.size() == 0) begin
			report("unexpected result, total_flow", 32'(r.total_flow), 0);
			return;
		end
		w = pending_flows.pop_front();
		if (r.total_flow !== w.total_flow)
			report("total_flow", 32'(r.total_flow), 32'(w.total_flow));
		if (r.paths_found !== w.paths_found)
			report("paths_found", 32'(r.paths_found), 32'(w.paths_found));
	endtask
endclass

module max_flow_dfs_augment_tb;
	import mfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	edge_item_t item;
	logic done;
	flow_result_t result;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [2:0] cfg_data;

	flow_scoreboard sb;
	int idle_cycles;
	int edges_sent;
	bit gaps_on;

	max_flow_dfs_augment uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Monitor: note accepted edges and check strobed results; watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_edge(item);
			if (done) sb.check_result(result);
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Drive one edge item and hold until accepted.
	task automatic send_edge(int f, int t, int c, bit last);
		edge_item_t it;
		it.from_node = 3'(f);
		it.to_node = 3'(t);
		it.edge_capacity = 8'(c);
		it.last_edge = last;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1;
		item <= it;
		do @(posedge clk); while (busy);
		edges_sent++;
		if (last) begin
			start <= 0;
			@(posedge clk);
		end
	endtask

	// Wait for all expected results, then a quiet margin before a config write.
	task automatic drain();
		start <= 0;
		while (sb.pending_flows.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 3'(val);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_SOURCE) sb.src_cfg = val;
		else sb.snk_cfg = val;
	endtask

	// Random graph: edges between random nodes, weights biased to 0 and 255.
	task automatic random_graph(int n_edges);
		int f, t, c;
		for (int k = 0; k < n_edges; k++) begin
			f = $urandom_range(0, 7);
			t = $urandom_range(0, 7);
			case ($urandom_range(0, 3))
				0: c = 255;
				1: c = 0;
				default: c = $urandom_range(0, 255);
			endcase
			send_edge(f, t, c, k == n_edges - 1);
		end
	endtask

	initial begin
		sb = new();
		sb.src_cfg = 0;
		sb.snk_cfg = 7;
		sb.clear_graph();
		start = 0;
		item = '0;
		cfg_we = 0;
		cfg_index = REG_SOURCE;
		cfg_data = 0;
		idle_cycles = 0;
		edges_sent = 0;
		gaps_on = 1;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty graph, single edge, chain, self loop, full weights.
		send_edge(0, 7, 0, 1);
		send_edge(0, 7, 255, 1);
		send_edge(0, 1, 200, 0);
		send_edge(1, 2, 100, 0);
		send_edge(1, 1, 50, 0);
		send_edge(2, 7, 150, 1);
		// Overwrite an edge before the last one.
		send_edge(0, 7, 10, 0);
		send_edge(0, 7, 20, 1);
		// Dense high-capacity graph to push totals up.
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 8; j++)
				send_edge(i, j, 255, i == 7 && j == 7);
		drain();
		// Source equal to sink.
		write_reg(REG_SOURCE, 3);
		write_reg(REG_SINK, 3);
		send_edge(3, 4, 9, 0);
		send_edge(4, 3, 9, 1);
		drain();
		// Reversed extremes.
		write_reg(REG_SOURCE, 7);
		write_reg(REG_SINK, 0);
		send_edge(7, 0, 33, 0);
		send_edge(7, 5, 255, 0);
		send_edge(5, 0, 1, 1);
		drain();

		// Random phases with varied endpoints.
		while (edges_sent < 950) begin
			if (edges_sent > 800) gaps_on = 0;
			if ($urandom_range(0, 3) == 0) begin
				drain();
				write_reg(REG_SOURCE, $urandom_range(0, 7));
				write_reg(REG_SINK, $urandom_range(0, 7));
			end
			random_graph($urandom_range(1, 24));
		end
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d edge items and %0d flow results", edges_sent, sb.checked);
		if (sb.errors == 0 && sb.pending_flows.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
